@@ hdl/bfp_pkg.sv @@
// Shared types and constants of the block floating point IQ compressor.
`default_nettype none

package bfp_pkg;

    // Field and word widths
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned MAG_W      = SAMPLE_W + 1;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned BITLEN_W   = 5;
    localparam int unsigned EXP_W      = 4;
    localparam int unsigned ACC_W      = 20;
    localparam int unsigned NBITS_W    = 5;

    // Compressed sample widths and their shift bases
    localparam int unsigned WIDTH_12      = 12;
    localparam int unsigned WIDTH_9       = 9;
    localparam int unsigned SHIFT_BASE_12 = 21;
    localparam int unsigned SHIFT_BASE_9  = 24;

    // Largest exponent bound: a full 17-bit magnitude in 9-bit mode
    localparam int unsigned EXP_MAX = MAG_W - (WORD_W - SHIFT_BASE_9);

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_OFFSET = 2'd1;

    // What the packer does in the current cycle
    typedef struct packed {
        logic take;   // one sample is consumed
        logic emit;   // one byte is produced
        logic last;   // that byte closes the block
    } t_pack_stat;

    // Bit length of a magnitude (32 minus its leading zeros as a 32-bit word)
    function automatic logic [BITLEN_W-1:0] bit_length(input logic [MAG_W-1:0] v);
        logic [BITLEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (v[i]) begin
                n = BITLEN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ hdl/bfp_iq_compressor_core.sv @@
// Top level of the block floating point IQ compressor.
`default_nettype none

// Collects PAIRS_PER_BLOCK IQ pairs, one per cycle while busy is low, tracking the
// largest magnitude. The last pair of a block raises busy; the block then works out
// the exponent in S_EXP and emits the exponent byte, followed by one packed byte per
// cycle from the bit packer (36 bytes at 12 bits, 27 at 9 bits with 12 pairs), the
// final one marked by o_last_byte. No new pair is taken until that last byte is
// emitted, so throughput is set by the single byte-wide output. Results carry
// o_strobe for one cycle and cannot be held off; configuration is sampled when the
// block is emitted.
module bfp_iq_compressor_core #(
    parameter int unsigned PAIRS_PER_BLOCK = 12
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [bfp_pkg::SAMPLE_W-1:0] i_i_sample,
    input  wire logic signed [bfp_pkg::SAMPLE_W-1:0] i_q_sample,
    input  wire logic                              i_cfg_we,
    input  wire logic [bfp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bfp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                   o_strobe,
    output logic [bfp_pkg::BYTE_W-1:0]             o_out_byte,
    output logic                                   o_last_byte
);

    localparam int unsigned SAMPLES  = 2 * PAIRS_PER_BLOCK;
    localparam int unsigned PAIR_AW  = (PAIRS_PER_BLOCK > 1) ? $clog2(PAIRS_PER_BLOCK) : 1;
    localparam int unsigned CNT_W    = $clog2(SAMPLES + 1);
    localparam int unsigned PAIR_W   = 2 * bfp_pkg::SAMPLE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXP,
        S_PACK
    } t_state;

    t_state r_state;

    logic                          r_width_mode;
    logic [bfp_pkg::CFG_DATA_W-1:0] r_exp_offset;
    logic [bfp_pkg::MAG_W-1:0]     r_max;
    logic [PAIR_AW-1:0]            r_pair_cnt;
    logic [CNT_W-1:0]              r_idx;
    logic [CNT_W-1:0]              n_idx;
    logic [bfp_pkg::EXP_W-1:0]     r_exp;
    logic [bfp_pkg::EXP_W-1:0]     n_exp;
    logic                          r_strobe;
    logic [bfp_pkg::BYTE_W-1:0]    r_out_byte;
    logic                          r_last_byte;

    logic [PAIR_W-1:0]             r_mem [PAIRS_PER_BLOCK];
    logic [PAIR_W-1:0]             r_rd_pair;

    logic                          accept;
    logic [bfp_pkg::MAG_W-1:0]     mag_i;
    logic [bfp_pkg::MAG_W-1:0]     mag_q;
    logic [bfp_pkg::MAG_W-1:0]     n_max;
    logic [bfp_pkg::BITLEN_W-1:0]  bitlen;
    logic [bfp_pkg::BITLEN_W-1:0]  knee;
    logic [bfp_pkg::SAMPLE_W-1:0]  cur_sample;

    bfp_pkg::t_pack_stat           stat;
    logic [bfp_pkg::BYTE_W-1:0]    pack_byte;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign o_strobe    = r_strobe;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_last_byte;

    // Configuration registers; writes to unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_mode <= 1'b1;
            r_exp_offset <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bfp_pkg::REG_WIDTH_MODE: r_width_mode <= i_cfg_data[0];
                bfp_pkg::REG_EXP_OFFSET: r_exp_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Magnitudes of the incoming pair; -32768 gives 32768
    always_comb begin
        mag_i = i_i_sample[bfp_pkg::SAMPLE_W-1]
              ? (bfp_pkg::MAG_W'(1 << bfp_pkg::SAMPLE_W) - {1'b0, i_i_sample})
              : {1'b0, i_i_sample};
        mag_q = i_q_sample[bfp_pkg::SAMPLE_W-1]
              ? (bfp_pkg::MAG_W'(1 << bfp_pkg::SAMPLE_W) - {1'b0, i_q_sample})
              : {1'b0, i_q_sample};
        n_max = r_max;
        if (mag_i > n_max) begin
            n_max = mag_i;
        end
        if (mag_q > n_max) begin
            n_max = mag_q;
        end
    end

    // Exponent: bit length of the peak above the width's knee, floored at zero
    always_comb begin
        bitlen = bfp_pkg::bit_length(r_max);
        knee   = r_width_mode
               ? bfp_pkg::BITLEN_W'(bfp_pkg::WORD_W - bfp_pkg::SHIFT_BASE_12)
               : bfp_pkg::BITLEN_W'(bfp_pkg::WORD_W - bfp_pkg::SHIFT_BASE_9);
        n_exp  = (bitlen > knee) ? bfp_pkg::EXP_W'(bitlen - knee) : '0;
    end

    // Sample index: reset for each block, stepped as the packer takes samples
    always_comb begin
        unique case (r_state)
            S_PACK:  n_idx = stat.take ? (r_idx + 1'b1) : r_idx;
            default: n_idx = '0;
        endcase
    end

    // Pair store: one pair written per accept, read ahead at the next index
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_pair_cnt] <= {i_i_sample, i_q_sample};
        end
        r_rd_pair <= r_mem[n_idx[PAIR_AW:1]];
    end

    assign cur_sample = r_idx[0] ? r_rd_pair[bfp_pkg::SAMPLE_W-1:0]
                                 : r_rd_pair[PAIR_W-1:bfp_pkg::SAMPLE_W];

    bfp_packer u_packer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (r_state == S_EXP),
        .i_advance    (r_state == S_PACK),
        .i_more       (r_idx != CNT_W'(SAMPLES)),
        .i_final      (r_idx == CNT_W'(SAMPLES - 1)),
        .i_sample     (cur_sample),
        .i_exp        (r_exp),
        .i_width_mode (r_width_mode),
        .o_stat       (stat),
        .o_byte       (pack_byte)
    );

    // Sequencer: collect pairs, emit the exponent byte, then drain the packer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max       <= '0;
            r_pair_cnt  <= '0;
            r_idx       <= '0;
            r_exp       <= '0;
            r_strobe    <= 1'b0;
            r_out_byte  <= '0;
            r_last_byte <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_idx    <= n_idx;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_max <= n_max;
                        if (r_pair_cnt == PAIR_AW'(PAIRS_PER_BLOCK - 1)) begin
                            r_pair_cnt <= '0;
                            r_state    <= S_EXP;
                        end else begin
                            r_pair_cnt <= r_pair_cnt + 1'b1;
                        end
                    end
                end
                S_EXP: begin
                    r_exp       <= n_exp;
                    r_strobe    <= 1'b1;
                    r_out_byte  <= bfp_pkg::BYTE_W'(n_exp) + r_exp_offset;
                    r_last_byte <= 1'b0;
                    r_max       <= '0;
                    r_state     <= S_PACK;
                end
                S_PACK: begin
                    if (stat.emit) begin
                        r_strobe    <= 1'b1;
                        r_out_byte  <= pack_byte;
                        r_last_byte <= stat.last;
                    end
                    if (stat.emit && stat.last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A byte is only ever produced by the exponent or packing steps
    a_strobe_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state != S_IDLE))
        else $error("strobe without a block in progress");

    // The closing byte hands the block back, ready for new pairs
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_byte) |-> !busy)
        else $error("block still busy after its last byte");

    // No pair is collected mid-emission
    a_no_collect_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_pair_cnt == '0))
        else $error("pair count moved while emitting");

    // Sample index stays within the block
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= CNT_W'(SAMPLES))
        else $error("sample index past end of block");

    // Exponent never exceeds what a 17-bit peak allows
    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exp <= bfp_pkg::EXP_W'(bfp_pkg::EXP_MAX))
        else $error("exponent out of range");

endmodule

`default_nettype wire

@@ hdl/bfp_packer.sv @@
// Bit packer: shifts samples by the exponent and cuts them into bytes, one byte per cycle while i_advance is high.
`default_nettype none

module bfp_packer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_clear,
    input  wire logic                          i_advance,
    input  wire logic                          i_more,
    input  wire logic                          i_final,
    input  wire logic [bfp_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic [bfp_pkg::EXP_W-1:0]     i_exp,
    input  wire logic                          i_width_mode,
    output bfp_pkg::t_pack_stat                o_stat,
    output logic [bfp_pkg::BYTE_W-1:0]         o_byte
);

    logic [bfp_pkg::ACC_W-1:0]    r_acc;
    logic [bfp_pkg::ACC_W-1:0]    n_acc;
    logic [bfp_pkg::NBITS_W-1:0]  r_nbits;
    logic [bfp_pkg::NBITS_W-1:0]  n_nbits;

    logic signed [bfp_pkg::SAMPLE_W-1:0] shifted;
    logic [bfp_pkg::ACC_W-1:0]    s_bits;
    logic [bfp_pkg::NBITS_W-1:0]  width;
    logic [bfp_pkg::ACC_W-1:0]    grown;
    logic [bfp_pkg::NBITS_W-1:0]  grown_n;

    // Scale the sample and append it below the bits still held
    always_comb begin
        shifted = $signed(i_sample) >>> i_exp;
        if (i_width_mode) begin
            width  = bfp_pkg::NBITS_W'(bfp_pkg::WIDTH_12);
            s_bits = bfp_pkg::ACC_W'(shifted[bfp_pkg::WIDTH_12-1:0]);
        end else begin
            width  = bfp_pkg::NBITS_W'(bfp_pkg::WIDTH_9);
            s_bits = bfp_pkg::ACC_W'(shifted[bfp_pkg::WIDTH_9-1:0]);
        end
        grown   = (r_acc << width) | s_bits;
        grown_n = r_nbits + width;
    end

    // Byte selection: drain a full byte, else take a sample, else flush the tail
    always_comb begin
        o_stat  = '0;
        o_byte  = '0;
        n_acc   = r_acc;
        n_nbits = r_nbits;
        if (r_nbits >= bfp_pkg::NBITS_W'(bfp_pkg::BYTE_W)) begin
            o_stat.emit = 1'b1;
            n_nbits     = r_nbits - bfp_pkg::NBITS_W'(bfp_pkg::BYTE_W);
            o_byte      = bfp_pkg::BYTE_W'(r_acc >> n_nbits);
            o_stat.last = !i_more && (n_nbits == '0);
        end else if (i_more) begin
            o_stat.take = 1'b1;
            o_stat.emit = 1'b1;
            n_acc       = grown;
            n_nbits     = grown_n - bfp_pkg::NBITS_W'(bfp_pkg::BYTE_W);
            o_byte      = bfp_pkg::BYTE_W'(grown >> n_nbits);
            o_stat.last = i_final && (n_nbits == '0);
        end else if (r_nbits != '0) begin
            // Partial last byte, padded with zeros at the bottom
            o_stat.emit = 1'b1;
            o_stat.last = 1'b1;
            o_byte      = bfp_pkg::BYTE_W'(r_acc << (bfp_pkg::NBITS_W'(bfp_pkg::BYTE_W) - r_nbits));
            n_nbits     = '0;
        end
    end

    // Bit count is control state; the accumulator is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nbits <= '0;
        end else if (i_clear) begin
            r_nbits <= '0;
        end else if (i_advance) begin
            r_nbits <= n_nbits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_acc <= n_acc;
        end
    end

endmodule

`default_nettype wire

@@ verif/bfp_iq_compressor_checker.sv @@
// Checker for the IQ compressor: predicts each compressed block and compares it byte by byte.
`default_nettype none

module bfp_iq_compressor_checker #(
    parameter int unsigned PAIRS_PER_BLOCK = 12
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic                                i_busy,
    input  wire logic signed [bfp_pkg::SAMPLE_W-1:0] i_i_sample,
    input  wire logic signed [bfp_pkg::SAMPLE_W-1:0] i_q_sample,
    input  wire logic                                i_cfg_we,
    input  wire logic [bfp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [bfp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                i_strobe,
    input  wire logic [bfp_pkg::BYTE_W-1:0]          i_out_byte,
    input  wire logic                                i_last_byte,
    output int                                       o_mismatches,
    output int                                       o_pending,
    output int                                       o_bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // One byte of a compressed block as the predictor expects it
    typedef struct packed {
        logic [bfp_pkg::BYTE_W-1:0] value;
        logic                       closes;
    } t_block_byte;

    t_block_byte                         block_bytes[$];
    logic signed [bfp_pkg::SAMPLE_W-1:0] held_samples[2*PAIRS_PER_BLOCK];
    logic [bfp_pkg::MAG_W-1:0]           peak_mag;
    int unsigned                         pairs_held;
    logic                                wide_mode;
    logic [bfp_pkg::BYTE_W-1:0]          exp_bias;
    int                                  mismatches;
    int                                  bytes_checked;

    // Magnitude of a sample; the most negative value maps to 32768.
    function automatic logic [bfp_pkg::MAG_W-1:0] magnitude(
        input logic signed [bfp_pkg::SAMPLE_W-1:0] s);
        logic signed [bfp_pkg::MAG_W-1:0] wide;
        wide = s;
        return (wide < 0) ? bfp_pkg::MAG_W'(-wide) : bfp_pkg::MAG_W'(wide);
    endfunction

    // Number of significant bits in a magnitude.
    function automatic int unsigned significant_bits(input logic [bfp_pkg::MAG_W-1:0] v);
        int unsigned n;
        n = 0;
        for (int b = bfp_pkg::MAG_W - 1; b >= 0; b--) begin
            if (v[b] && n == 0) begin
                n = b + 1;
            end
        end
        return n;
    endfunction

    // Work out the exponent, shift every held sample and pack the block into bytes.
    function automatic void compress_block();
        int unsigned  width;
        int unsigned  headroom;
        int unsigned  used;
        int unsigned  expo;
        int unsigned  nbits;
        logic [31:0]  acc;
        logic [31:0]  field;
        t_block_byte  packed_bytes[$];
        width    = wide_mode ? bfp_pkg::WIDTH_12 : bfp_pkg::WIDTH_9;
        headroom = bfp_pkg::WORD_W
                 - (wide_mode ? bfp_pkg::SHIFT_BASE_12 : bfp_pkg::SHIFT_BASE_9);
        used     = significant_bits(peak_mag);
        expo     = (used > headroom) ? used - headroom : 0;
        packed_bytes.push_back('{value: bfp_pkg::BYTE_W'(expo + exp_bias), closes: 1'b0});
        acc   = '0;
        nbits = 0;
        for (int k = 0; k < 2 * PAIRS_PER_BLOCK; k++) begin
            field = 32'(held_samples[k] >>> expo) & ((32'd1 << width) - 32'd1);
            acc   = (acc << width) | field;
            nbits += width;
            while (nbits >= 8) begin
                nbits -= 8;
                packed_bytes.push_back('{value: bfp_pkg::BYTE_W'(acc >> nbits), closes: 1'b0});
            end
        end
        // A partial tail byte is padded with zeros at the bottom.
        if (nbits > 0) begin
            packed_bytes.push_back('{value: bfp_pkg::BYTE_W'(acc << (8 - nbits)),
                                     closes: 1'b0});
        end
        packed_bytes[packed_bytes.size() - 1].closes = 1'b1;
        foreach (packed_bytes[j]) begin
            block_bytes.push_back(packed_bytes[j]);
        end
    endfunction

    // Store an accepted pair and close the block on its last pair.
    function automatic void take_pair(input logic signed [bfp_pkg::SAMPLE_W-1:0] iv,
                                      input logic signed [bfp_pkg::SAMPLE_W-1:0] qv);
        held_samples[2*pairs_held]     = iv;
        held_samples[2*pairs_held + 1] = qv;
        if (magnitude(iv) > peak_mag) begin
            peak_mag = magnitude(iv);
        end
        if (magnitude(qv) > peak_mag) begin
            peak_mag = magnitude(qv);
        end
        pairs_held++;
        if (pairs_held == PAIRS_PER_BLOCK) begin
            compress_block();
            pairs_held = 0;
            peak_mag   = '0;
        end
    endfunction

    // Compare one output byte with the oldest expected byte.
    function automatic void check_byte();
        t_block_byte want;
        if (block_bytes.size() == 0) begin
            $error("out_byte 0x%02h arrived with no block byte expected", i_out_byte);
            mismatches++;
            return;
        end
        want = block_bytes.pop_front();
        bytes_checked++;
        if (i_out_byte !== want.value) begin
            $error("out_byte mismatch: expected 0x%02h, actual 0x%02h", want.value, i_out_byte);
            mismatches++;
        end
        if (i_last_byte !== want.closes) begin
            $error("last_byte mismatch: expected %0b, actual %0b", want.closes, i_last_byte);
            mismatches++;
        end
    endfunction

    // Watch the configuration port, the input handshake and the byte strobe.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            block_bytes.delete();
            pairs_held    = 0;
            peak_mag      = '0;
            wide_mode     = 1'b1;
            exp_bias      = '0;
            mismatches    = 0;
            bytes_checked = 0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bfp_pkg::REG_WIDTH_MODE: wide_mode = i_cfg_data[0];
                    bfp_pkg::REG_EXP_OFFSET: exp_bias = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_strobe) begin
                check_byte();
            end
            if (i_start && !i_busy) begin
                take_pair(i_i_sample, i_q_sample);
            end
        end
        o_mismatches    <= mismatches;
        o_pending       <= block_bytes.size();
        o_bytes_checked <= bytes_checked;
    end

endmodule

`default_nettype wire

@@ verif/bfp_iq_compressor_core_tb.sv @@
// Testbench top for the IQ compressor: drives pairs and register writes and gives the verdict.
`default_nettype none

module bfp_iq_compressor_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PAIRS        = 12;
    localparam int          TOTAL_PAIRS  = 280;
    localparam int          CALM_TAIL    = 48;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [bfp_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [bfp_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic signed [bfp_pkg::SAMPLE_W-1:0] i_i_sample = '0;
    logic signed [bfp_pkg::SAMPLE_W-1:0] i_q_sample = '0;
    logic                                i_cfg_we = 1'b0;
    logic [bfp_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [bfp_pkg::CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                                o_strobe;
    logic [bfp_pkg::BYTE_W-1:0]          o_out_byte;
    logic                                o_last_byte;

    int mismatches;
    int pending_bytes;
    int bytes_checked;
    int cycles = 0;
    int pairs_sent = 0;
    int blocks_sent = 0;
    int block_span;
    bit idle_on;

    bfp_iq_compressor_core #(
        .PAIRS_PER_BLOCK(PAIRS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_i_sample  (i_i_sample),
        .i_q_sample  (i_q_sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    bfp_iq_compressor_checker #(
        .PAIRS_PER_BLOCK(PAIRS)
    ) block_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_i_sample      (i_i_sample),
        .i_q_sample      (i_q_sample),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_strobe        (o_strobe),
        .i_out_byte      (o_out_byte),
        .i_last_byte     (o_last_byte),
        .o_mismatches    (mismatches),
        .o_pending       (pending_bytes),
        .o_bytes_checked (bytes_checked)
    );

    always #1 i_clk = ~i_clk;

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one pair and hold it until the block takes it.
    task automatic send_pair(input logic [bfp_pkg::SAMPLE_W-1:0] iv,
                             input logic [bfp_pkg::SAMPLE_W-1:0] qv);
        start      <= 1'b1;
        i_i_sample <= iv;
        i_q_sample <= qv;
        do @(posedge i_clk); while (busy);
        pairs_sent++;
    endtask

    // Sometimes drop start for a short burst.
    task automatic maybe_idle();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every predicted byte has been seen.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bfp_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [bfp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random sample whose magnitude stays within 2**span; a negative span gives zero.
    function automatic logic [bfp_pkg::SAMPLE_W-1:0] rand_sample(input int span);
        logic [31:0] r;
        r = $urandom;
        if (span < 0) begin
            return '0;
        end
        if (span == 15 && $urandom_range(0, 7) == 0) begin
            unique case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'hFFFF;
                default: return 16'h0001;
            endcase
        end
        return 16'($signed(r) >>> (31 - span));
    endfunction

    // Stimulus: directed blocks, then random phases of varying configuration.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration with the extreme sample values.
        idle_on = 1'b0;
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h0000, 16'hFFFF);
        send_pair(16'h0001, 16'hFFFE);
        send_pair(16'h4000, 16'hC000);
        send_pair(16'h5555, 16'hAAAA);
        send_pair(16'h00FF, 16'hFF00);
        send_pair(16'h07FF, 16'hF800);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h0064, 16'hFF9C);
        send_pair(16'h0000, 16'h0000);
        send_pair(16'hFFFF, 16'h0001);
        send_pair(16'h3039, 16'hCFC7);
        blocks_sent++;
        drain();

        // Unused register indexes must be ignored; then narrow width, top offset.
        write_reg(REG_SPARE_A, 8'h00);
        write_reg(REG_SPARE_B, 8'hFF);
        write_reg(bfp_pkg::REG_WIDTH_MODE, 8'h00);
        write_reg(bfp_pkg::REG_EXP_OFFSET, 8'hFF);

        // All-zero block, with the offset changed halfway through the block.
        idle_on = 1'b1;
        for (int p = 0; p < PAIRS; p++) begin
            if (p == PAIRS / 2) begin
                drain();
                write_reg(bfp_pkg::REG_EXP_OFFSET, 8'h80);
            end
            send_pair('0, '0);
            maybe_idle();
        end
        blocks_sent++;

        // Random phases: each starts from an idle block with a fresh setting,
        // except in the closing stretch, which keeps the input busy throughout.
        for (int phase = 0; pairs_sent < TOTAL_PAIRS; phase++) begin
            if (pairs_sent < TOTAL_PAIRS - CALM_TAIL) begin
                drain();
                unique case (phase)
                    0: begin
                        write_reg(bfp_pkg::REG_WIDTH_MODE, 8'h01);
                        write_reg(bfp_pkg::REG_EXP_OFFSET, 8'h00);
                    end
                    1: begin
                        write_reg(bfp_pkg::REG_WIDTH_MODE, 8'hFE);
                        write_reg(bfp_pkg::REG_EXP_OFFSET, 8'hFF);
                    end
                    default: begin
                        write_reg(bfp_pkg::REG_WIDTH_MODE, bfp_pkg::CFG_DATA_W'($urandom));
                        write_reg(bfp_pkg::REG_EXP_OFFSET, bfp_pkg::CFG_DATA_W'($urandom));
                        if ($urandom_range(0, 3) == 0) begin
                            write_reg(REG_SPARE_B, bfp_pkg::CFG_DATA_W'($urandom));
                        end
                    end
                endcase
            end
            repeat ($urandom_range(1, 3)) begin
                if (pairs_sent < TOTAL_PAIRS) begin
                    idle_on    = (pairs_sent < TOTAL_PAIRS - CALM_TAIL)
                              && ($urandom_range(0, 3) != 0);
                    block_span = ($urandom_range(0, 9) == 0) ? -1 : int'($urandom_range(0, 15));
                    for (int p = 0; p < PAIRS; p++) begin
                        // Occasionally retune the offset in the middle of a block.
                        if (p == PAIRS / 2 && idle_on && $urandom_range(0, 5) == 0) begin
                            drain();
                            write_reg(bfp_pkg::REG_EXP_OFFSET, bfp_pkg::CFG_DATA_W'($urandom));
                        end
                        send_pair(rand_sample(block_span), rand_sample(block_span));
                        maybe_idle();
                    end
                    blocks_sent++;
                end
            end
        end

        // Let the last block finish, then give the verdict.
        drain();
        repeat (16) @(posedge i_clk);
        $display("Sent %0d IQ pairs in %0d blocks; %0d compressed bytes were compared.",
                 pairs_sent, blocks_sent, bytes_checked);
        $display("Both sample widths, offsets 0 and 255, unused register writes and zero blocks ran.");
        if (pending_bytes != 0) begin
            $error("%0d block bytes never arrived", pending_bytes);
        end
        if (mismatches == 0 && pending_bytes == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/bfp_pkg.sv
hdl/bfp_packer.sv
hdl/bfp_iq_compressor_core.sv
verif/bfp_iq_compressor_checker.sv
verif/bfp_iq_compressor_core_tb.sv
